// ===== hw/rtl/mrfc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus request
// frame checker. No dependencies; every other file imports this package.

package mrfc_pkg;

  localparam logic [15:0] CRC_POLY          = 16'h1021;
  localparam logic [7:0]  FAULT_FLAG        = 8'h80;
  localparam logic [7:0]  MIN_FRAME         = 8'd7;
  localparam logic [7:0]  HDR_LEN           = 8'd6;
  localparam logic [7:0]  DLY_LEN           = 8'd2;
  localparam logic [7:0]  LEN_MAX           = 8'd255;
  localparam logic [7:0]  STATION_RESET     = 8'd1;

  localparam logic [7:0]  FUNC_READ_HOLD    = 8'h03;
  localparam logic [7:0]  FUNC_READ_INPUT   = 8'h04;
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0]  FUNC_WRITE_MULTI  = 8'd16;

  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  typedef enum logic [2:0] {
    V_IGNORE       = 3'd0,
    V_FAULT        = 3'd1,
    V_READ_HOLD    = 3'd2,
    V_READ_INPUT   = 3'd3,
    V_WRITE_SINGLE = 3'd4,
    V_WRITE_MULTI  = 3'd5
  } verdict_t;

  // One finished frame, handed from the byte front end to the verdict stage
  typedef struct packed {
    logic [5:0][7:0] hdr;        // first six bytes, zero where not received
    logic [7:0]      len;        // saturating byte count
    logic            crc_ok;     // running CRC matched the trailing two bytes
    logic [15:0]     first_crc;  // CRC over the address byte alone
    logic [15:0]     six_crc;    // CRC over the first six bytes
  } frame_rec_t;

  // Feed one byte, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (b[7-k] != c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/mrfc_front.sv =====
// Byte front end: counts bytes, captures the header, runs both CRCs and the
// two-byte delay line, and emits one frame record on the last byte. Uses mrfc_pkg.

module mrfc_front import mrfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       in_full,
  input  logic       q_full,
  output logic       q_wr,
  output frame_rec_t q_wdata
);

  logic [7:0]      count_r, count_nxt;
  logic [15:0]     run_r, run_nxt;
  logic [15:0]     six_r, six_nxt;
  logic [15:0]     first_r, first_nxt;
  logic [1:0][7:0] dly_r, dly_nxt;
  logic [5:0][7:0] hdr_r, hdr_nxt;
  logic            accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    hdr_nxt = hdr_r;
    six_nxt = six_r;
    if (count_r < HDR_LEN) begin
      hdr_nxt[count_r[2:0]] = in_data_byte;
      six_nxt = crc_feed(six_r, in_data_byte);
    end
    first_nxt = (count_r == 8'd0) ? six_nxt : first_r;
    // the oldest byte leaves the delay line into the running CRC
    run_nxt   = (count_r >= DLY_LEN) ? crc_feed(run_r, dly_r[0]) : run_r;
    dly_nxt   = {in_data_byte, dly_r[1]};
    count_nxt = (count_r == LEN_MAX) ? LEN_MAX : count_r + 8'd1;
  end

  assign q_wr = accept && in_last;

  always_comb begin
    q_wdata.hdr       = hdr_nxt;
    q_wdata.len       = count_nxt;
    q_wdata.crc_ok    = (run_nxt == {dly_r[1], in_data_byte});
    q_wdata.first_crc = first_nxt;
    q_wdata.six_crc   = six_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last)) begin
      count_r <= '0;
      run_r   <= '0;
      six_r   <= '0;
      first_r <= '0;
      dly_r   <= '0;
      hdr_r   <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
      run_r   <= run_nxt;
      six_r   <= six_nxt;
      first_r <= first_nxt;
      dly_r   <= dly_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

endmodule

// ===== hw/rtl/mrfc_queue.sv =====
// Short queue of frame records between the front end and the verdict stage.
// Uses mrfc_pkg for the record type.

module mrfc_queue import mrfc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr,
  input  frame_rec_t wdata,
  output logic       full,
  input  logic       rd,
  output logic       avail,
  output frame_rec_t rdata
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_rec_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign avail = (cnt_r != '0);
  assign rdata = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) begin
      wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
    end
    if (rd) begin
      rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wp_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !avail |-> !rd)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_FULL)
    else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/mrfc_back.sv =====
// Verdict stage: holds the station address, classifies the frame record at
// the queue head and loads the result register. Uses mrfc_pkg.

module mrfc_back import mrfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        q_avail,
  input  frame_rec_t  q_rdata,
  output logic        q_rd,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [2:0]  out_verdict,
  output logic [7:0]  out_function_code,
  output logic [7:0]  out_frame_length,
  output logic [15:0] out_register_address,
  output logic [15:0] out_register_count,
  output logic [15:0] out_fault_crc,
  output logic [15:0] out_ack_crc
);

  logic [7:0]  station_r;
  logic        valid_r;
  verdict_t    verdict_r, verdict_nxt;
  logic [7:0]  fn_r, len_r;
  logic [15:0] addr_r, cnt_r, fcrc_r, fcrc_nxt, ack_r;
  logic [7:0]  fn;

  assign fn   = q_rdata.hdr[1];
  assign q_rd = q_avail && (!valid_r || out_pop);

  always_comb begin
    if (q_rdata.len < MIN_FRAME || q_rdata.hdr[0] != station_r || !q_rdata.crc_ok) begin
      verdict_nxt = V_IGNORE;
    end else if (q_rdata.hdr[2] != 8'd0) begin
      verdict_nxt = V_FAULT;
    end else begin
      case (fn)
        FUNC_READ_HOLD:    verdict_nxt = V_READ_HOLD;
        FUNC_READ_INPUT:   verdict_nxt = V_READ_INPUT;
        FUNC_WRITE_SINGLE: verdict_nxt = V_WRITE_SINGLE;
        FUNC_WRITE_MULTI:  verdict_nxt = V_WRITE_MULTI;
        default:           verdict_nxt = V_FAULT;
      endcase
    end
    // address byte CRC was taken up front; add the flagged function code
    fcrc_nxt = crc_feed(q_rdata.first_crc, fn + FAULT_FLAG);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= STATION_RESET;
    end else if (cfg_we) begin
      station_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_rd) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      verdict_r <= verdict_nxt;
      fn_r      <= fn;
      len_r     <= q_rdata.len;
      addr_r    <= {q_rdata.hdr[2], q_rdata.hdr[3]};
      cnt_r     <= {q_rdata.hdr[4], q_rdata.hdr[5]};
      fcrc_r    <= fcrc_nxt;
      ack_r     <= q_rdata.six_crc;
    end
  end

  assign out_empty            = !valid_r;
  assign out_verdict          = verdict_r;
  assign out_function_code    = fn_r;
  assign out_frame_length     = len_r;
  assign out_register_address = addr_r;
  assign out_register_count   = cnt_r;
  assign out_fault_crc        = fcrc_r;
  assign out_ack_crc          = ack_r;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
      valid_r && !out_pop |=> valid_r && $stable(verdict_r) && $stable(fcrc_r))
    else $error("result changed while stalled");
  a_short_ignored: assert property (@(posedge clk) disable iff (!rst_n)
      valid_r && len_r < MIN_FRAME |-> verdict_r == V_IGNORE)
    else $error("short frame not ignored");
  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
      q_rd |-> !valid_r || out_pop)
    else $error("result register overwritten");

endmodule

// ===== hw/rtl/modbus_request_frame_checker.sv =====
// Modbus request frame checker, top level.
//
// Input channel: one frame byte per item on in_data_byte, with in_last high
// on the final byte. An item is taken when in_push is high and in_full low.
// Bytes are taken back to back, one per cycle; in_full rises only when the
// record queue between front end and verdict stage is full.
//
// Result channel: one result per frame, nothing for other bytes. The result
// is on the out_ ports while out_empty is low and leaves on out_pop. The
// frame record is first written to the record queue and then loaded into
// the result register. A stalled receiver holds the result register;
// further frames collect in the queue (QUEUE_DEPTH records) and then
// bytes back up through in_full.
//
// CRC is CRC-16 poly 0x1021, init 0, MSB first, one byte per cycle while in_full is low.
// cfg_we writes cfg_data to the station address at once; write it only
// while the block is idle.
//
// Reset (rst_n low at a clock edge) clears the frame state and both
// channels, and sets the station address to 1.
// Depends on mrfc_pkg, mrfc_front, mrfc_queue and mrfc_back.

module modbus_request_frame_checker import mrfc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_push,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [2:0]  out_verdict,
  output logic [7:0]  out_function_code,
  output logic [7:0]  out_frame_length,
  output logic [15:0] out_register_address,
  output logic [15:0] out_register_count,
  output logic [15:0] out_fault_crc,
  output logic [15:0] out_ack_crc
);

  logic       q_full, q_wr, q_rd, q_avail;
  frame_rec_t q_wdata, q_rdata;

  mrfc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .in_full      (in_full),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_wdata      (q_wdata)
  );

  mrfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .avail (q_avail),
    .rdata (q_rdata)
  );

  mrfc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .q_avail              (q_avail),
    .q_rdata              (q_rdata),
    .q_rd                 (q_rd),
    .out_pop              (out_pop),
    .out_empty            (out_empty),
    .out_verdict          (out_verdict),
    .out_function_code    (out_function_code),
    .out_frame_length     (out_frame_length),
    .out_register_address (out_register_address),
    .out_register_count   (out_register_count),
    .out_fault_crc        (out_fault_crc),
    .out_ack_crc          (out_ack_crc)
  );

endmodule

// ===== sim/modbus_request_frame_checker_tb.sv =====
// Self-checking testbench for modbus_request_frame_checker: a short stimulus table, then
// random request frames under several station addresses and idling mixes.
// Depends on mrfc_pkg and the checker RTL; results are predicted in the bench itself.

module modbus_request_frame_checker_tb;
  import mrfc_pkg::*;

  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_CRC_HI,
    SRC_CRC_LO
  } byte_src_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  fn;
    logic [7:0]  len;
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [15:0] fcrc;
    logic [15:0] acrc;
  } frame_result_t;

  // typed marks a final byte whose header fields are written out here;
  // the two CRC fields always come from the predictor
  typedef struct packed {
    byte_src_t   src;
    logic [7:0]  data;
    logic        is_last;
    logic        typed;
    verdict_t    verdict;
    logic [7:0]  fn;
    logic [7:0]  len;
    logic [15:0] addr;
    logic [15:0] cnt;
  } dir_row_t;

  localparam int DIR_ROWS    = 30;
  localparam int BLOCK_BYTES = 200;
  localparam int NUM_BLOCKS  = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_push = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        in_full;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic [2:0]  out_verdict;
  logic [7:0]  out_function_code;
  logic [7:0]  out_frame_length;
  logic [15:0] out_register_address;
  logic [15:0] out_register_count;
  logic [15:0] out_fault_crc;
  logic [15:0] out_ack_crc;

  // Predictor state
  logic [7:0]  own_station;
  logic [7:0]  fr_count;
  logic [15:0] fr_crc;
  logic [15:0] fr_six;
  logic [7:0]  fr_tail [2];
  logic [7:0]  fr_hdr [6];

  frame_result_t pending_verdicts [$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int failures = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int verdict_seen [6] = '{default: 0};

  dir_row_t dir_table [DIR_ROWS] = '{
    // one-byte frame straight after reset
    '{SRC_LIT,    8'hFF, 1'b1, 1'b1, V_IGNORE,     8'h00, 8'd1, 16'h0000, 16'h0000},
    // shortest valid frame, read holding
    '{SRC_LIT,    8'h01, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h03, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_CRC_HI, 8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_CRC_LO, 8'h00, 1'b1, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    // read input
    '{SRC_LIT,    8'h01, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h04, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'hFF, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'hFF, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_CRC_HI, 8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_CRC_LO, 8'h00, 1'b1, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    // write single
    '{SRC_LIT,    8'h01, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h06, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h7F, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h80, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_CRC_HI, 8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_CRC_LO, 8'h00, 1'b1, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    // write multiple, full header
    '{SRC_LIT,    8'h01, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h10, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'hFF, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_LIT,    8'h01, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_CRC_HI, 8'h00, 1'b0, 1'b0, V_IGNORE,     8'h00, 8'd0, 16'h0000, 16'h0000},
    '{SRC_CRC_LO, 8'h00, 1'b1, 1'b1, V_WRITE_MULTI, 8'h10, 8'd8, 16'h00FF, 16'h0001}
  };

  modbus_request_frame_checker uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_data             (cfg_data),
    .in_push              (in_push),
    .in_data_byte         (in_data_byte),
    .in_last              (in_last),
    .in_full              (in_full),
    .out_pop              (out_pop),
    .out_empty            (out_empty),
    .out_verdict          (out_verdict),
    .out_function_code    (out_function_code),
    .out_frame_length     (out_frame_length),
    .out_register_address (out_register_address),
    .out_register_count   (out_register_count),
    .out_fault_crc        (out_fault_crc),
    .out_ack_crc          (out_ack_crc)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // XMODEM CRC, whole byte folded into the top then shifted out
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    return r;
  endfunction

  function automatic void clear_frame();
    fr_count = 8'd0;
    fr_crc = 16'h0000;
    fr_six = 16'h0000;
    fr_tail = '{default: 8'h00};
    fr_hdr = '{default: 8'h00};
  endfunction

  // Advance the predicted frame state by one byte; returns 1 with the verdict on a final byte
  function automatic bit classify_byte(input logic [7:0] b, input logic is_last,
                                       output frame_result_t r);
    logic [7:0] fn;
    r = '0;
    if (fr_count < HDR_LEN) begin
      fr_hdr[fr_count] = b;
      fr_six = crc_byte(fr_six, b);
    end
    if (fr_count >= DLY_LEN) fr_crc = crc_byte(fr_crc, fr_tail[0]);
    fr_tail[0] = fr_tail[1];
    fr_tail[1] = b;
    if (fr_count != LEN_MAX) fr_count = fr_count + 8'd1;
    if (!is_last) return 1'b0;

    fn = fr_hdr[1];
    r.fn = fn;
    r.len = fr_count;
    r.addr = {fr_hdr[2], fr_hdr[3]};
    r.cnt = {fr_hdr[4], fr_hdr[5]};
    r.fcrc = crc_byte(crc_byte(16'h0000, fr_hdr[0]), fn + FAULT_FLAG);
    r.acrc = fr_six;
    if (fr_count < MIN_FRAME || fr_hdr[0] != own_station ||
        fr_crc != {fr_tail[0], fr_tail[1]}) begin
      r.verdict = V_IGNORE;
    end else if (fr_hdr[2] != 8'h00) begin
      r.verdict = V_FAULT;
    end else begin
      case (fn)
        FUNC_READ_HOLD:    r.verdict = V_READ_HOLD;
        FUNC_READ_INPUT:   r.verdict = V_READ_INPUT;
        FUNC_WRITE_SINGLE: r.verdict = V_WRITE_SINGLE;
        FUNC_WRITE_MULTI:  r.verdict = V_WRITE_MULTI;
        default:           r.verdict = V_FAULT;
      endcase
    end
    clear_frame();
    return 1'b1;
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      failures++;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last, input logic typed,
                           input frame_result_t want);
    frame_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data_byte <= b;
    in_last <= is_last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
    if (is_last) frames_sent++;
    if (classify_byte(b, is_last, r)) begin
      if (typed) begin
        r.verdict = want.verdict;
        r.fn = want.fn;
        r.len = want.len;
        r.addr = want.addr;
        r.cnt = want.cnt;
      end
      pending_verdicts.push_back(r);
    end
  endtask

  // Hold the sender until every predicted verdict has been collected or the guard runs out
  task automatic settle();
    int guard;
    guard = 0;
    in_push <= 1'b0;
    while (pending_verdicts.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_station(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    own_station = v;
  endtask

  task automatic send_random_frame(input bit force_long);
    logic [7:0] fb [$];
    logic [15:0] c;
    int unsigned pick, n, idx;
    fb = {};
    pick = $urandom_range(99);
    if (pick < 8 && !force_long) begin
      // noise: random bytes of random length
      n = $urandom_range(12, 1);
      repeat (n) fb.push_back(8'($urandom));
    end else begin
      fb.push_back(($urandom_range(9) == 0) ? 8'($urandom) : own_station);
      case ($urandom_range(9))
        0, 1:    fb.push_back(FUNC_READ_HOLD);
        2, 3:    fb.push_back(FUNC_READ_INPUT);
        4, 5:    fb.push_back(FUNC_WRITE_SINGLE);
        6, 7:    fb.push_back(FUNC_WRITE_MULTI);
        default: fb.push_back(8'($urandom));
      endcase
      fb.push_back(($urandom_range(7) == 0) ? 8'($urandom) : 8'h00);
      repeat (3) fb.push_back(8'($urandom));
      if (force_long || $urandom_range(149) == 0) n = $urandom_range(280, 250);
      else if (fb[1] == FUNC_WRITE_MULTI) n = $urandom_range(8);
      else n = ($urandom_range(5) == 0) ? $urandom_range(3) : 0;
      repeat (n) fb.push_back(8'($urandom));
      // drop the tail of the header now and then for short frames
      if ($urandom_range(11) == 0) fb = fb[0:$urandom_range(4)];
      c = 16'h0000;
      foreach (fb[i]) c = crc_byte(c, fb[i]);
      fb.push_back(c[15:8]);
      fb.push_back(c[7:0]);
      if ($urandom_range(9) == 0) begin
        idx = $urandom_range(fb.size() - 1);
        fb[idx] = fb[idx] ^ (8'h01 << $urandom_range(7));
      end
    end
    foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1, 1'b0, '0);
    if ($urandom_range(24) == 0) settle();
  endtask

  // Receiver: check the item on the result ports when it is taken, then choose the next pop
  always @(posedge clk) begin
    frame_result_t want;
    if (out_pop && !out_empty) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with none expected, verdict %0d length %0d",
                 $time, out_verdict, out_frame_length);
        failures++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 16'(want.verdict), 16'(out_verdict));
        check_field("function_code", 16'(want.fn), 16'(out_function_code));
        check_field("frame_length", 16'(want.len), 16'(out_frame_length));
        check_field("register_address", want.addr, out_register_address);
        check_field("register_count", want.cnt, out_register_count);
        check_field("fault_crc", want.fcrc, out_fault_crc);
        check_field("ack_crc", want.acrc, out_ack_crc);
        results_seen++;
        verdict_seen[want.verdict]++;
      end
    end
    out_pop <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #400000;
    $display("%0t: run did not finish in time", $time);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    dir_row_t row;
    frame_result_t want;
    logic [15:0] tx_crc;
    logic [15:0] tx_hold;
    logic [7:0] b;
    int start;
    own_station = STATION_RESET;
    clear_frame();
    tx_crc = 16'h0000;
    tx_hold = 16'h0000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 24;
    rx_idle_pct = 79;
    foreach (dir_table[i]) begin
      row = dir_table[i];
      case (row.src)
        SRC_CRC_HI: begin
          tx_hold = tx_crc;
          b = tx_hold[15:8];
        end
        SRC_CRC_LO: b = tx_hold[7:0];
        default:    b = row.data;
      endcase
      tx_crc = row.is_last ? 16'h0000 : crc_byte(tx_crc, b);
      want = '0;
      want.verdict = row.verdict;
      want.fn = row.fn;
      want.len = row.len;
      want.addr = row.addr;
      want.cnt = row.cnt;
      send_byte(b, row.is_last, row.typed, want);
    end

    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      settle();
      case (blk / 2)
        0: begin
          tx_idle_pct = 24;
          rx_idle_pct = 79;
        end
        1: begin
          tx_idle_pct = 79;
          rx_idle_pct = 24;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (blk)
        0:       write_station(8'h00);
        1:       write_station(8'hFF);
        3:       write_station(STATION_RESET);
        default: write_station(8'($urandom));
      endcase
      start = bytes_sent;
      // one long frame, which saturates the length unless its header tail is dropped
      if (blk == 4) send_random_frame(1'b1);
      while (bytes_sent - start < BLOCK_BYTES) send_random_frame(1'b0);
    end

    settle();
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
      failures++;
    end
    $display("Covered %0d bytes in %0d frames, %0d results checked, six station settings",
             bytes_sent, frames_sent, results_seen);
    $display("Verdicts: ignore %0d fault %0d rd-hold %0d rd-input %0d wr-single %0d wr-multi %0d",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
             verdict_seen[4], verdict_seen[5]);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mrfc_pkg.sv
hw/rtl/mrfc_front.sv
hw/rtl/mrfc_queue.sv
hw/rtl/mrfc_back.sv
hw/rtl/modbus_request_frame_checker.sv
sim/modbus_request_frame_checker_tb.sv
